/* rtl/core/qrv_pkg.sv */
package qrv_pkg;

  localparam int QUAT_WIDTH   = 16;
  localparam int THRESH_WIDTH = 16;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd32;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  typedef struct packed {
    logic valid;
    logic degen;
  } stage_ctl_t;

endpackage

/* rtl/core/quaternion_rotate_vector.sv */
// Rotates a vector by a quaternion of any length, one beat per clock. A beat is taken
// when start is high and busy is low; the result appears on rot_x/rot_y/rot_z with done
// high for exactly one cycle, after the product register, the matrix and multiply stages,
// the queue write and registered read, the divider load stage, one stage per quotient bit
// of the VEC_WIDTH+2 bit rounding divider, and the output register.
// The receiver cannot stall; busy only rises if the internal queue between the matrix
// front end and the divider could fill, which at full rate it does not.
// The threshold register is written with cfg_we/cfg_wdata and should change only while idle.
module quaternion_rotate_vector
  import qrv_pkg::*;
#(
  parameter int VEC_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [THRESH_WIDTH-1:0]      cfg_wdata,
  input  logic signed [QUAT_WIDTH-1:0] quat_x,
  input  logic signed [QUAT_WIDTH-1:0] quat_y,
  input  logic signed [QUAT_WIDTH-1:0] quat_z,
  input  logic signed [QUAT_WIDTH-1:0] quat_w,
  input  logic signed [VEC_WIDTH-1:0]  vec_x,
  input  logic signed [VEC_WIDTH-1:0]  vec_y,
  input  logic signed [VEC_WIDTH-1:0]  vec_z,
  output logic                         done,
  output logic signed [VEC_WIDTH-1:0]  rot_x,
  output logic signed [VEC_WIDTH-1:0]  rot_y,
  output logic signed [VEC_WIDTH-1:0]  rot_z,
  output logic                         degenerate,
  output logic                         saturated
);

  localparam int EW = 3*(2*QUAT_WIDTH+VEC_WIDTH+7)+2*QUAT_WIDTH+2+1+3*VEC_WIDTH;

  logic [THRESH_WIDTH-1:0] threshold;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic push, rvalid;
  logic [EW-1:0] push_data, rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  qrv_front #(.VW(VEC_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .quat_x     (quat_x),
    .quat_y     (quat_y),
    .quat_z     (quat_z),
    .quat_w     (quat_w),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .threshold  (threshold),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  qrv_fifo #(.WIDTH(EW)) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_data),
    .count  (fifo_count),
    .rvalid (rvalid),
    .rdata  (rdata)
  );

  qrv_back #(.VW(VEC_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .rvalid     (rvalid),
    .rdata      (rdata),
    .done       (done),
    .rot_x      (rot_x),
    .rot_y      (rot_y),
    .rot_z      (rot_z),
    .degenerate (degenerate),
    .saturated  (saturated)
  );

endmodule

/* rtl/core/qrv_front.sv */
module qrv_front
  import qrv_pkg::*;
#(
  parameter int VW = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [QUAT_WIDTH-1:0]  quat_x,
  input  logic signed [QUAT_WIDTH-1:0]  quat_y,
  input  logic signed [QUAT_WIDTH-1:0]  quat_z,
  input  logic signed [QUAT_WIDTH-1:0]  quat_w,
  input  logic signed [VW-1:0]          vec_x,
  input  logic signed [VW-1:0]          vec_y,
  input  logic signed [VW-1:0]          vec_z,
  input  logic [THRESH_WIDTH-1:0]       threshold,
  input  logic [FIFO_CNT_W-1:0]         fifo_count,
  output logic                          push,
  output logic [3*(2*QUAT_WIDTH+VW+7)+2*QUAT_WIDTH+2+1+3*VW-1:0] push_data
);

  localparam int PW = 2*QUAT_WIDTH;
  localparam int NW = PW+1;
  localparam int MW = PW+2;
  localparam int TW = MW+VW;
  localparam int SW = TW+2;
  localparam int DW = SW+2;

  logic accept;
  logic [FIFO_CNT_W-1:0] inflight;

  stage_ctl_t c1, c2, c3;
  logic signed [PW-1:0] pxx, pyy, pzz, pww, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [VW-1:0] v1 [3];
  logic signed [VW-1:0] v2 [3];
  logic signed [VW-1:0] v3 [3];
  logic [NW-1:0] n2, n3;
  logic signed [MW-1:0] m2 [9];
  logic signed [MW-1:0] m_next [9];
  logic [NW-1:0] n_next;
  logic degen_next;
  logic signed [TW-1:0] t3 [9];
  logic signed [MW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
  logic signed [SW-1:0] dot [3];
  logic [SW-1:0] mag [3];
  logic [DW-1:0] dvd [3];

  assign accept   = start && !busy;
  assign inflight = FIFO_CNT_W'(c1.valid) + FIFO_CNT_W'(c2.valid) + FIFO_CNT_W'(c3.valid);
  assign busy     = (fifo_count + inflight) >= FIFO_CNT_W'(FIFO_DEPTH);

  // stage 1: quaternion products
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else begin
      c1.valid <= accept;
      c1.degen <= 1'b0;
    end
    pxx <= quat_x * quat_x;
    pyy <= quat_y * quat_y;
    pzz <= quat_z * quat_z;
    pww <= quat_w * quat_w;
    pxy <= quat_x * quat_y;
    pxz <= quat_x * quat_z;
    pyz <= quat_y * quat_z;
    pwx <= quat_w * quat_x;
    pwy <= quat_w * quat_y;
    pwz <= quat_w * quat_z;
    v1[0] <= vec_x;
    v1[1] <= vec_y;
    v1[2] <= vec_z;
  end

  assign exx = MW'(pxx);
  assign eyy = MW'(pyy);
  assign ezz = MW'(pzz);
  assign eww = MW'(pww);
  assign exy = MW'(pxy);
  assign exz = MW'(pxz);
  assign eyz = MW'(pyz);
  assign ewx = MW'(pwx);
  assign ewy = MW'(pwy);
  assign ewz = MW'(pwz);

  always_comb begin
    m_next[0] = eww + exx - eyy - ezz;
    m_next[1] = (exy - ewz) <<< 1;
    m_next[2] = (exz + ewy) <<< 1;
    m_next[3] = (exy + ewz) <<< 1;
    m_next[4] = eww - exx + eyy - ezz;
    m_next[5] = (eyz - ewx) <<< 1;
    m_next[6] = (exz - ewy) <<< 1;
    m_next[7] = (eyz + ewx) <<< 1;
    m_next[8] = eww - exx - eyy + ezz;
    n_next = NW'($unsigned(exx + eyy + ezz + eww));
    degen_next = (n_next == '0) || (n_next < NW'(threshold));
  end

  // stage 2: rotation matrix scaled by the squared length
  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
    end else begin
      c2.valid <= c1.valid;
      c2.degen <= degen_next;
    end
    m2 <= m_next;
    n2 <= n_next;
    v2 <= v1;
  end

  // stage 3: matrix times vector products
  always_ff @(posedge clk) begin
    if (rst) begin
      c3 <= '0;
    end else begin
      c3 <= c2;
    end
    for (int i = 0; i < 9; i++) begin
      t3[i] <= m2[i] * v2[i%3];
    end
    n3 <= n2;
    v3 <= v2;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot[i] = SW'(t3[3*i]) + SW'(t3[3*i+1]) + SW'(t3[3*i+2]);
      mag[i] = dot[i][SW-1] ? $unsigned(-dot[i]) : $unsigned(dot[i]);
      dvd[i] = {1'b0, mag[i], 1'b0} + DW'(n3);
    end
  end

  assign push = c3.valid;
  assign push_data = {dvd[0], dot[0][SW-1], dvd[1], dot[1][SW-1], dvd[2], dot[2][SW-1],
                      n3, 1'b0, c3.degen, v3[0], v3[1], v3[2]};

endmodule

/* rtl/core/qrv_fifo.sv */
module qrv_fifo
  import qrv_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  output logic [FIFO_CNT_W-1:0] count,
  output logic                  rvalid,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic pop;

  assign pop = count != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
    if (pop) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= pop;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("queue overflow");

  a_stays_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && !push) |=> (count == '0 && !rvalid) == ($past(count) == '0 && 1'b1))
    else $error("queue left empty state without a push");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count != '0)
    else $error("pushed beat lost");

endmodule

/* rtl/core/qrv_back.sv */
module qrv_back
  import qrv_pkg::*;
#(
  parameter int VW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rvalid,
  input  logic [3*(2*QUAT_WIDTH+VW+7)+2*QUAT_WIDTH+2+1+3*VW-1:0] rdata,
  output logic                 done,
  output logic signed [VW-1:0] rot_x,
  output logic signed [VW-1:0] rot_y,
  output logic signed [VW-1:0] rot_z,
  output logic                 degenerate,
  output logic                 saturated
);

  localparam int PW = 2*QUAT_WIDTH;
  localparam int NW = PW+1;
  localparam int MW = PW+2;
  localparam int TW = MW+VW;
  localparam int SW = TW+2;
  localparam int DW = SW+2;
  localparam int QB = VW+2;
  localparam int LW = DW+1;
  localparam logic [QB-1:0] MAG_HI = {3'b000, {(VW-1){1'b1}}};
  localparam logic [QB-1:0] MAG_LO = {3'b001, {(VW-1){1'b0}}};

  logic [QB:0] val;
  logic [DW-1:0] rem [QB+1][3];
  logic [QB-1:0] quo [QB+1][3];
  logic [2:0] neg [QB+1];
  logic [DW-1:0] dvs [QB+1];
  logic degen [QB+1];
  logic signed [VW-1:0] vin [QB+1][3];

  logic [VW-1:0] res [3];
  logic [2:0] sat;
  logic [QB-1:0] qneg [3];

  // long division, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else begin
      val <= {val[QB-1:0], rvalid};
    end
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= rdata[3*VW+2+NW+(2-i)*LW+1 +: DW];
      neg[0][i] <= rdata[3*VW+2+NW+(2-i)*LW +: 1];
      quo[0][i] <= '0;
      vin[0][i] <= rdata[(2-i)*VW +: VW];
    end
    dvs[0]   <= DW'({rdata[3*VW+2 +: NW], 1'b0});
    degen[0] <= rdata[3*VW];
    for (int s = 0; s < QB; s++) begin
      for (int i = 0; i < 3; i++) begin
        if (rem[s][i] >= (dvs[s] << (QB-1-s))) begin
          rem[s+1][i] <= rem[s][i] - (dvs[s] << (QB-1-s));
          quo[s+1][i] <= quo[s][i] | (QB'(1) << (QB-1-s));
        end else begin
          rem[s+1][i] <= rem[s][i];
          quo[s+1][i] <= quo[s][i];
        end
        vin[s+1][i] <= vin[s][i];
      end
      neg[s+1]   <= neg[s];
      dvs[s+1]   <= dvs[s];
      degen[s+1] <= degen[s];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qneg[i] = ~quo[QB][i] + 1'b1;
      if (degen[QB]) begin
        res[i] = vin[QB][i];
        sat[i] = 1'b0;
      end else if (neg[QB][i]) begin
        sat[i] = quo[QB][i] > MAG_LO;
        res[i] = sat[i] ? {1'b1, {(VW-1){1'b0}}} : qneg[i][VW-1:0];
      end else begin
        sat[i] = quo[QB][i] > MAG_HI;
        res[i] = sat[i] ? {1'b0, {(VW-1){1'b1}}} : quo[QB][i][VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= val[QB];
    end
    rot_x      <= res[0];
    rot_y      <= res[1];
    rot_z      <= res[2];
    degenerate <= degen[QB];
    saturated  <= |sat;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import qrv_pkg::*;

  localparam int VW = 16;
  localparam int LATENCY = VW + 9;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [VW-1:0] vx, vy, vz;
  } rot_req_t;

  typedef struct packed {
    logic signed [VW-1:0] x, y, z;
    logic degen;
    logic sat;
  } rot_res_t;

  typedef struct {
    rot_req_t req;
    bit       known;
    rot_res_t res;
  } dir_row_t;

  logic clk, rst, start, busy, cfg_we;
  logic [THRESH_WIDTH-1:0] cfg_wdata;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [VW-1:0] vec_x, vec_y, vec_z;
  logic done, degenerate, saturated;
  logic signed [VW-1:0] rot_x, rot_y, rot_z;

  rot_res_t expected_q[$];
  longint unsigned threshold;
  int fail_cnt;
  int idle_cycles;
  int send_idle_pct;
  int mode;

  quaternion_rotate_vector #(.VEC_WIDTH(VW)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .degenerate(degenerate), .saturated(saturated)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint row_quot(longint a0, longint a1, longint a2,
                                      longint v0, longint v1, longint v2, longint n);
    longint s, q, r;
    s = a0 * v0 + a1 * v1 + a2 * v2;
    q = s / n;
    r = s % n;
    if (r >= 0) begin
      if (2 * r >= n) q++;
    end else begin
      if (-2 * r >= n) q--;
    end
    return q;
  endfunction

  function automatic rot_res_t rotate_vec(rot_req_t r);
    rot_res_t o;
    longint x, y, z, w, n, c;
    longint m[3][3];
    longint v[3];
    longint res[3];
    x = r.qx; y = r.qy; z = r.qz; w = r.qw;
    v[0] = r.vx; v[1] = r.vy; v[2] = r.vz;
    n = x * x + y * y + z * z + w * w;
    o.sat = 0;
    o.degen = 0;
    if (n == 0 || n < threshold) begin
      o.degen = 1;
      for (int i = 0; i < 3; i++) res[i] = v[i];
    end else begin
      m[0][0] = w*w + x*x - y*y - z*z; m[0][1] = 2*(x*y - w*z); m[0][2] = 2*(x*z + w*y);
      m[1][0] = 2*(x*y + w*z); m[1][1] = w*w - x*x + y*y - z*z; m[1][2] = 2*(y*z - w*x);
      m[2][0] = 2*(x*z - w*y); m[2][1] = 2*(y*z + w*x); m[2][2] = w*w - x*x - y*y + z*z;
      for (int i = 0; i < 3; i++) begin
        c = row_quot(m[i][0], m[i][1], m[i][2], v[0], v[1], v[2], n);
        if (c > 32767) begin c = 32767; o.sat = 1; end
        if (c < -32768) begin c = -32768; o.sat = 1; end
        res[i] = c;
      end
    end
    o.x = VW'(res[0]); o.y = VW'(res[1]); o.z = VW'(res[2]);
    return o;
  endfunction

  always @(posedge clk) begin
    if (start && !busy && !rst) idle_cycles <= 0;
    else if (done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rot_res_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time, rot_x, rot_y, rot_z);
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (rot_x !== e.x || rot_y !== e.y || rot_z !== e.z) begin
          $display("%0t: vector expected %0d %0d %0d actual %0d %0d %0d", $time,
                   e.x, e.y, e.z, rot_x, rot_y, rot_z);
          fail_cnt++;
        end
        if (degenerate !== e.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, degenerate);
          fail_cnt++;
        end
        if (saturated !== e.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, e.sat, saturated);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_beat(rot_req_t r, bit known, rot_res_t kres);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    {quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z} <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(known ? kres : rotate_vec(r));
  endtask

  task automatic drain();
    start <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] t);
    cfg_we <= 1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 0;
    threshold = t;
  endtask

  function automatic logic signed [15:0] rand_quat_comp(int m);
    case (m)
      0: return 16'($urandom_range(65535));
      1: return 16'sd16384 - 16'($urandom_range(64));
      2: return 16'($urandom_range(15)) - 16'sd8;
      default: return $signed(16'($urandom_range(32767))) - 16'sd16384;
    endcase
  endfunction

  function automatic rot_req_t rand_req();
    rot_req_t r;
    int m;
    m = $urandom_range(3);
    r.qx = rand_quat_comp(m == 1 ? 2 : m);
    r.qy = rand_quat_comp(m == 1 ? 2 : m);
    r.qz = rand_quat_comp(m);
    r.qw = rand_quat_comp(m);
    r.vx = VW'($urandom_range(65535));
    r.vy = VW'($urandom_range(65535));
    r.vz = VW'($urandom_range(65535));
    if ($urandom_range(3) == 0) begin
      r.vx = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      r.vy = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    return r;
  endfunction

  dir_row_t dir_rows[$];

  task automatic add_row(logic [15:0] qx, qy, qz, qw, vx, vy, vz,
                         bit known = 0, rot_res_t res = '0);
    dir_row_t d;
    d.req = {qx, qy, qz, qw, vx, vy, vz};
    d.known = known;
    d.res = res;
    dir_rows.push_back(d);
  endtask

  initial begin
    rot_res_t none;
    none = '0;
    send_idle_pct = 0;
    threshold = 32;
    rst = 1;
    start = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    {quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z} = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero quaternion and below reset threshold: pass through
    add_row(0, 0, 0, 0, 16'h7fff, 16'h8000, 16'h0001, 1, {16'h7fff, 16'h8000, 16'h0001, 2'b10});
    add_row(0, 0, 0, 5, 16'h1234, 16'hffff, 16'h8000, 1, {16'h1234, 16'hffff, 16'h8000, 2'b10});
    // identity, unit and non-unit, then other rotations and corner cases
    add_row(0, 0, 0, 16384, 100, -200, 300, 1, {16'd100, -16'sd200, 16'd300, 2'b00});
    add_row(0, 0, 0, -32768, 16'h7fff, 16'h8000, 5, 1, {16'h7fff, 16'h8000, 16'd5, 2'b00});
    add_row(0, 0, 0, 7, 1, 2, 3);
    add_row(11585, 0, 0, 11585, 1000, 2000, 3000);
    add_row(0, 11585, 0, 11585, 16'h7fff, 16'h7fff, 16'h7fff);
    add_row(0, 0, 11585, 11585, 16'h7fff, 16'h8000, 16'h7fff);
    add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_row(16'h7fff, 16'h8000, 0, 1, 16'h7fff, 16'h7fff, 0);
    add_row(1, 1, 1, 1, 1, 0, 0);
    add_row(16384, 0, 0, 0, 3, -3, 1);
    add_row(3, 0, 0, 1, 1, 1, 1);
    add_row(1, 2, 3, 4, 7, -7, 5);
    foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
    drain();

    set_threshold(16'd0);
    add_row(0, 0, 0, 0, 9, 9, 9, 1, {16'd9, 16'd9, 16'd9, 2'b10});
    add_row(0, 0, 0, 1, 9, -9, 9, 1, {16'd9, -16'sd9, 16'd9, 2'b00});
    for (int i = 15; i < dir_rows.size(); i++)
      send_beat(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
    drain();

    set_threshold(16'hffff);
    send_beat({16'sd0, 16'sd0, 16'sd0, 16'sd255, 16'sd4, -16'sd4, 16'sd1}, 1,
              {16'd4, -16'sd4, 16'd1, 2'b10});
    send_beat({16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd4, -16'sd4, 16'sd1}, 1,
              {16'd4, -16'sd4, 16'd1, 2'b00});
    drain();

    for (mode = 0; mode < 6; mode++) begin
      case (mode % 4)
        0: send_idle_pct = 0;
        1: send_idle_pct = 48;
        2: send_idle_pct = 0;
        default: send_idle_pct = 28;
      endcase
      case (mode)
        0: set_threshold(16'd32);
        1: set_threshold(16'($urandom_range(65535)));
        2: set_threshold(16'hffff);
        3: set_threshold(16'd0);
        default: set_threshold(16'($urandom_range(255)));
      endcase
      for (int k = 0; k < 300; k++) begin
        if (k % 100 == 99) send_idle_pct = (send_idle_pct == 0) ? 48 : 0;
        send_beat(rand_req(), 0, none);
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
